>>> design/ccfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared types, codes and the CRC-16/CCITT byte update for the receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 250;
	localparam int REGION_CAP_DEF  = 256;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_COBS     = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_LENGTH   = 3'd4,
		ST_CRC      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		EV_MORE  = 2'd0,
		EV_READY = 2'd1,
		EV_ERROR = 2'd2
	} event_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
		logic [7:0] read_index;
	} in_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [2:0] status;
		logic [7:0] frame_type;
		logic [7:0] frame_length;
		logic [7:0] read_byte;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDWAIT,
		S_FETCH,
		S_PROC,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic push;
		logic read;
		logic read_done;
		logic fetch;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic walk_needed;
		logic walk_end;
	} sts_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> design/ccfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_ctrl
// Sequencer: input handshake, read-back wait and the region decode walk.
// ----------------------------------------------------------------------------
module ccfr_ctrl
	import ccfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_op,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !sts.out_busy;
				if (in_valid && !sts.out_busy) begin
					if (in_op == OP_READ) begin
						cmd.read = 1'b1;
						state_d  = S_RDWAIT;
					end else begin
						cmd.push = 1'b1;
						if (sts.walk_needed) state_d = S_FETCH;
					end
				end
			end
			S_RDWAIT: begin
				cmd.read_done = 1'b1;
				state_d       = S_IDLE;
			end
			S_FETCH: begin
				if (sts.walk_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.fetch = 1'b1;
					state_d   = S_PROC;
				end
			end
			S_PROC: begin
				cmd.step = 1'b1;
				state_d  = S_FETCH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> design/ccfr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_datapath
// Region store, online COBS decoder with CRC, double-banked payload store
// and the result register.
// ----------------------------------------------------------------------------
module ccfr_datapath
	import ccfr_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int REGION_CAP  = REGION_CAP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  in_t  in_data,
	input  cmd_t cmd,
	output sts_t sts,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int RAW_CAP = MAX_PAYLOAD + 4;
	localparam int CW      = $clog2(REGION_CAP + 1);
	localparam int AW      = $clog2(REGION_CAP);
	localparam int OW      = $clog2(RAW_CAP + 2);
	localparam int PAW     = $clog2(2 * MAX_PAYLOAD);
	localparam logic [PAW-1:0] BANK1 = PAW'(MAX_PAYLOAD);

	logic [7:0]     region_mem [REGION_CAP];
	logic [7:0]     pay_mem [2 * MAX_PAYLOAD];

	logic [CW-1:0]  count_q, wlen_q, i_q;
	logic           ovf_q;
	logic [2:0]     status_q;
	logic [7:0]     type_q, length_q;
	logic           bank_q;
	logic           out_valid_q;
	out_t           out_q;

	logic [7:0]     rdata_q, prdata_q;
	logic           rd_ok_q;
	logic [7:0]     rem_q;
	logic           ff_q, pend_q, fault_q;
	logic [OW-1:0]  o_q;
	logic [7:0]     h0_q, h1_q, dtype_q, dlen_q;
	logic [15:0]    crc_q;

	logic           push_nz, rd_ok;
	logic [PAW-1:0] rd_addr, wr_addr;
	logic           emit;
	logic [7:0]     eb;
	logic [2:0]     fin_status;
	logic [OW-1:0]  plen_ext;

	assign push_nz = in_data.data_byte != 8'h00;
	assign rd_ok   = (in_data.read_index < length_q) &&
		(32'(in_data.read_index) < MAX_PAYLOAD);
	assign rd_addr = (bank_q ? BANK1 : '0) + (rd_ok ? PAW'(in_data.read_index) : '0);
	assign wr_addr = (bank_q ? '0 : BANK1) + PAW'(o_q - OW'(2));

	assign sts.out_busy    = out_valid_q && !out_ready;
	assign sts.walk_needed = !push_nz && (count_q != '0) && !ovf_q;
	assign sts.walk_end    = i_q == wlen_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		emit = 1'b0;
		eb   = rdata_q;
		if (rem_q == 8'h00) begin
			emit = pend_q;
			eb   = 8'h00;
		end else begin
			emit = 1'b1;
		end
	end

	always_comb begin
		plen_ext = OW'(dlen_q) + OW'(4);
		if (fault_q || rem_q != 8'h00) begin
			fin_status = ST_COBS;
		end else if (o_q < OW'(4)) begin
			fin_status = ST_TRUNC;
		end else if (32'(dlen_q) > MAX_PAYLOAD || o_q != plen_ext) begin
			fin_status = ST_LENGTH;
		end else if ({h0_q, h1_q} != crc_q) begin
			fin_status = ST_CRC;
		end else begin
			fin_status = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && push_nz && (32'(count_q) < REGION_CAP)) begin
			region_mem[count_q[AW-1:0]] <= in_data.data_byte;
		end
		if (cmd.fetch) begin
			rdata_q <= region_mem[i_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && emit && !fault_q && (32'(o_q) < RAW_CAP) && (o_q >= OW'(2)) &&
			(32'(o_q) - 2 < MAX_PAYLOAD)) begin
			pay_mem[wr_addr] <= eb;
		end
		if (cmd.read) begin
			prdata_q <= pay_mem[rd_addr];
			rd_ok_q  <= rd_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			wlen_q  <= count_q;
			i_q     <= '0;
			rem_q   <= 8'h00;
			ff_q    <= 1'b0;
			pend_q  <= 1'b0;
			fault_q <= 1'b0;
			o_q     <= '0;
			crc_q   <= CRC_INIT;
		end
		if (cmd.step) begin
			i_q <= i_q + CW'(1);
			if (rem_q == 8'h00) begin
				if (rdata_q == 8'h00) fault_q <= 1'b1;
				rem_q  <= rdata_q - 8'h01;
				ff_q   <= rdata_q == 8'hFF;
				pend_q <= rdata_q == 8'h01;
			end else begin
				rem_q <= rem_q - 8'h01;
				if (rem_q == 8'h01) pend_q <= !ff_q;
			end
			if (emit && !fault_q) begin
				if (32'(o_q) >= RAW_CAP) begin
					fault_q <= 1'b1;
				end else begin
					o_q  <= o_q + OW'(1);
					h0_q <= eb;
					h1_q <= h0_q;
					if (o_q == OW'(0)) dtype_q <= eb;
					if (o_q == OW'(1)) dlen_q <= eb;
					if (o_q >= OW'(2)) crc_q <= crc_update(crc_q, h1_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			status_q    <= ST_OK;
			type_q      <= 8'h00;
			length_q    <= 8'h00;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.push) begin
				if (push_nz) begin
					if (32'(count_q) < REGION_CAP) count_q <= count_q + CW'(1);
					else ovf_q <= 1'b1;
					out_valid_q <= 1'b1;
					out_q       <= '{EV_MORE, status_q, type_q, length_q, 8'h00};
				end else if (ovf_q) begin
					count_q     <= '0;
					ovf_q       <= 1'b0;
					status_q    <= ST_OVERFLOW;
					out_valid_q <= 1'b1;
					out_q       <= '{EV_ERROR, ST_OVERFLOW, type_q, length_q, 8'h00};
				end else if (count_q == '0) begin
					out_valid_q <= 1'b1;
					out_q       <= '{EV_MORE, status_q, type_q, length_q, 8'h00};
				end else begin
					count_q <= '0;
				end
			end
			if (cmd.read_done) begin
				out_valid_q <= 1'b1;
				out_q <= '{EV_MORE, status_q, type_q, length_q,
					rd_ok_q ? prdata_q : 8'h00};
			end
			if (cmd.finish) begin
				status_q    <= fin_status;
				out_valid_q <= 1'b1;
				if (fin_status == ST_OK) begin
					bank_q   <= !bank_q;
					type_q   <= dtype_q;
					length_q <= dlen_q;
					out_q    <= '{EV_READY, ST_OK, dtype_q, dlen_q, 8'h00};
				end else begin
					out_q <= '{EV_ERROR, fin_status, type_q, length_q, 8'h00};
				end
			end
		end
	end

endmodule

>>> design/cobs_crc_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver
// Push byte: result registered on acceptance; read: registered payload store read, then the result register.
// Delimiter closing a region that did not overflow: each byte takes the region store
// read (S_FETCH) and the decode/CRC step (S_PROC), then S_FINISH; no item is taken meanwhile.
// Asynchronous active-low reset clears counters, status, latched frame and
// result valid; stores hold no reset and need no clearing pass.
// ----------------------------------------------------------------------------
module cobs_crc_frame_receiver
	import ccfr_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int REGION_CAP  = REGION_CAP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	cmd_t cmd;
	sts_t sts;

	ccfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_op    (in_data.operation),
		.sts      (sts),
		.cmd      (cmd)
	);

	ccfr_datapath #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.REGION_CAP  (REGION_CAP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> tb/cobs_crc_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver_tb
// Drives link bytes and payload reads through the valid/ready input channel.
// Each transfer is scored against a cycle-free model of the frame receiver
// (COBS unstuffing, length checks, CRC-16/CCITT), with random gaps on both
// channels, a long output stall and full drains before that stall, at random and at the end.
// ----------------------------------------------------------------------------
module cobs_crc_frame_receiver_tb;
	import ccfr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	cobs_crc_frame_receiver dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	logic [7:0] region_mem [256];
	int         region_cnt;
	bit         region_ovf;
	status_t    last_st;
	logic [7:0] lat_type;
	logic [7:0] lat_len;
	logic [7:0] payload_mem [250];

	out_t expected_q[$];
	int   errors;
	int   items_sent;
	bit   idle_en;
	int   out_wait;
	int   long_hold;

	function automatic logic [15:0] crc16(ref logic [7:0] buf_b[254], input int n);
		logic [15:0] c;
		c = 16'hFFFF;
		for (int i = 0; i < n; i++) begin
			c = c ^ {buf_b[i], 8'h00};
			for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		end
		return c;
	endfunction

	function automatic status_t region_check(input int len);
		logic [7:0] raw [254];
		int i, o, c, plen;
		logic [15:0] rx;
		i = 0;
		o = 0;
		while (i < len) begin
			c = region_mem[i];
			i = i + 1;
			if (c == 0) return ST_COBS;
			for (int k = 1; k < c; k++) begin
				if (i >= len || o >= 254) return ST_COBS;
				raw[o] = region_mem[i];
				o = o + 1;
				i = i + 1;
			end
			if (c < 255 && i < len) begin
				if (o >= 254) return ST_COBS;
				raw[o] = 8'h00;
				o = o + 1;
			end
		end
		if (o < 4) return ST_TRUNC;
		plen = raw[1];
		if (plen > 250 || o != plen + 4) return ST_LENGTH;
		rx = {raw[plen + 3], raw[plen + 2]};
		if (rx != crc16(raw, plen + 2)) return ST_CRC;
		lat_type = raw[0];
		lat_len = plen[7:0];
		for (int j = 0; j < plen; j++) payload_mem[j] = raw[j + 2];
		return ST_OK;
	endfunction

	function automatic out_t rx_predict(input in_t t);
		out_t r;
		status_t st;
		r = '0;
		r.event_res = EV_MORE;
		if (t.operation == OP_PUSH) begin
			if (t.data_byte != 8'h00) begin
				if (region_cnt < 256) begin
					region_mem[region_cnt] = t.data_byte;
					region_cnt = region_cnt + 1;
				end else begin
					region_ovf = 1'b1;
				end
			end else if (region_cnt != 0 || region_ovf) begin
				st = region_ovf ? ST_OVERFLOW : region_check(region_cnt);
				region_cnt = 0;
				region_ovf = 1'b0;
				last_st = st;
				r.event_res = (st == ST_OK) ? EV_READY : EV_ERROR;
			end
		end else if (t.read_index < lat_len) begin
			r.read_byte = payload_mem[t.read_index];
		end
		r.status = last_st;
		r.frame_type = lat_type;
		r.frame_length = lat_len;
		return r;
	endfunction

	task automatic report(input string what, input int got, input int exp);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		out_t e;
		if (arst_n && in_valid && in_ready) expected_q.push_back(rx_predict(in_data));
		if (arst_n && out_valid && out_ready) begin
			out_wait = idle_en ? $urandom_range(0, 10) : 0;
			if (expected_q.size() == 0) begin
				report("unexpected transfer", 1, 0);
			end else begin
				e = expected_q.pop_front();
				if (out_data.event_res !== e.event_res)
					report("event_res", out_data.event_res, e.event_res);
				if (out_data.status !== e.status) report("status", out_data.status, e.status);
				if (out_data.frame_type !== e.frame_type)
					report("frame_type", out_data.frame_type, e.frame_type);
				if (out_data.frame_length !== e.frame_length)
					report("frame_length", out_data.frame_length, e.frame_length);
				if (out_data.read_byte !== e.read_byte)
					report("read_byte", out_data.read_byte, e.read_byte);
			end
		end
	end

	always @(negedge clk) begin
		if (long_hold > 0) begin
			out_ready <= 1'b0;
			long_hold = long_hold - 1;
		end else if (out_wait > 0) begin
			out_ready <= 1'b0;
			out_wait = out_wait - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_item(input in_t t);
		int gap;
		gap = idle_en ? $urandom_range(0, 10) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		in_t t;
		t.operation = OP_PUSH;
		t.data_byte = b;
		t.read_index = 8'($urandom_range(0, 255));
		send_item(t);
	endtask

	task automatic read_at(input logic [7:0] idx);
		in_t t;
		t.operation = OP_READ;
		t.data_byte = 8'($urandom_range(0, 255));
		t.read_index = idx;
		send_item(t);
	endtask

	// kind: 0 good, 1 bad crc, 2 bad length, 3 truncated, 4 flipped link byte
	task automatic send_frame(input int plen, input int kind);
		logic [7:0] raw[$];
		logic [7:0] enc[$];
		logic [15:0] c;
		int code, code_at, p;
		raw.push_back(8'($urandom_range(0, 255)));
		raw.push_back(plen[7:0]);
		for (int i = 0; i < plen; i++)
			raw.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
		c = 16'hFFFF;
		foreach (raw[i]) begin
			c = c ^ {raw[i], 8'h00};
			for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		end
		raw.push_back(c[7:0]);
		raw.push_back(c[15:8]);
		case (kind)
			1: raw[plen + 2] = raw[plen + 2] ^ 8'($urandom_range(1, 255));
			2: raw[1] = raw[1] ^ 8'($urandom_range(1, 255));
			3: while (raw.size() > $urandom_range(1, 3)) void'(raw.pop_back());
			default: ;
		endcase
		enc.push_back(8'h00);
		code_at = 0;
		code = 1;
		foreach (raw[i]) begin
			if (raw[i] == 8'h00) begin
				enc[code_at] = 8'(code);
				code_at = enc.size();
				enc.push_back(8'h00);
				code = 1;
			end else begin
				enc.push_back(raw[i]);
				code++;
				if (code == 255) begin
					enc[code_at] = 8'(code);
					code_at = enc.size();
					enc.push_back(8'h00);
					code = 1;
				end
			end
		end
		enc[code_at] = 8'(code);
		if (kind == 4) begin
			p = $urandom_range(0, enc.size() - 1);
			enc[p] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 255))
				: 8'($urandom_range(1, 8));
		end
		foreach (enc[i]) push_byte(enc[i]);
		push_byte(8'h00);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		read_at(8'd0);
		push_byte(8'h00);
		send_frame(0, 0);
		read_at(8'd0);
		send_frame(250, 0);
		read_at(8'd0);
		read_at(8'd249);
		read_at(8'd250);
		read_at(8'd255);
		send_frame(3, 3);
		push_byte(8'h05);
		push_byte(8'h01);
		push_byte(8'h00);
		send_frame(4, 2);
		send_frame(4, 1);
		repeat (260) push_byte(8'hFF);
		push_byte(8'h00);
		read_at(8'd1);
		send_frame(1, 0);
		send_frame(253, 0);
	endtask

	task automatic test_long_stall();
		wait_drained();
		idle_en = 1'b0;
		long_hold = 400;
		send_frame(6, 0);
		for (int i = 0; i < 30; i++) read_at(8'($urandom_range(0, 7)));
		idle_en = 1'b1;
	endtask

	task automatic test_random();
		int pick;
		while (items_sent < 1150) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_frame(($urandom_range(0, 29) == 0) ? $urandom_range(0, 250)
					: $urandom_range(0, 12), 0);
			else if (pick < 60) send_frame($urandom_range(0, 10), $urandom_range(1, 4));
			else if (pick < 78)
				read_at(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 15)));
			else if (pick < 98) push_byte(8'($urandom_range(0, 255)));
			else if (pick < 99) begin
				repeat ($urandom_range(257, 270)) push_byte(8'($urandom_range(1, 255)));
				push_byte(8'h00);
			end else begin
				wait_drained();
				idle_en = ($urandom_range(0, 3) != 0);
			end
		end
	endtask

	initial begin
		region_cnt = 0;
		region_ovf = 1'b0;
		last_st = ST_OK;
		lat_type = '0;
		lat_len = '0;
		errors = 0;
		items_sent = 0;
		idle_en = 1'b1;
		out_wait = 0;
		long_hold = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_long_stall();
		test_random();
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
